// ===== rtl/owch_pkg.sv =====
// Shared types and constants for the overlapping-window class histogram.
package owch_pkg;

  // Commands carried in s_tuser
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] CFG_WINDOW_STEP = 2'd1;
  localparam logic [1:0] CFG_BINS_ACROSS = 2'd2;
  localparam logic [1:0] CFG_BINS_DOWN   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Shared divider operand widths
  localparam int DIV_NUM_W = 12;
  localparam int DIV_DEN_W = 11;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FETCH,
    ST_UPDATE,
    ST_PEEK,
    ST_CLEAR,
    ST_CLEAR_WAIT,
    ST_DONE
  } state_t;

  // Sequencer to counter store
  typedef struct packed {
    logic rd;
    logic inc;
    logic clear;
  } mem_ctl_t;

  // Counter store back to sequencer
  typedef struct packed {
    logic busy;
    logic at_max;
  } mem_sts_t;

endpackage

// ===== rtl/overlapping_window_class_histogram_top.sv =====
// Per-class overlapping-window histogram: one request in flight, sequenced over a shared divider
// and one counter memory port. An add runs four divisions through the shared divider (start,
// 12 quotient bits, done), then a read-modify-write per covered window, besides taking the
// request and loading the output register; a read fetches one counter. A clear, and reset
// itself, run a clearing pass over every counter entry (262144 at the defaults) during which
// no request is taken; configuration writes are taken only between requests.
// The output register lets the next request enter while a result waits on m_tready.
module overlapping_window_class_histogram_top #(
  parameter int NUM_CLASSES = 256,
  parameter int MAX_BINS_X  = 32,
  parameter int MAX_BINS_Y  = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [owch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owch_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [owch_pkg::IN_DATA_W-1:0]    s_tdata,   // class_code[8:0], pos_x[18:9], pos_y[28:19]
  input  logic [1:0]                        s_tuser,   // cmd[1:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [owch_pkg::OUT_DATA_W-1:0]   m_tdata,   // count_value[15:0], bins_touched[26:16]
  output logic [0:0]                        m_tuser    // saturated[0]
);
  import owch_pkg::*;

  localparam int XW    = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
  localparam int YW    = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEPTH = NUM_CLASSES * (1 << (XW + YW));
  localparam int AW    = $clog2(DEPTH);

  state_t state, state_next;

  logic [10:0] window_size, window_step;
  logic [5:0]  bins_across, bins_down;

  logic [1:0]  cmd;
  logic [7:0]  cls;
  logic [9:0]  px, py;
  logic [1:0]  div_sel;
  logic [9:0]  q_tmp;
  logic [10:0] r_tmp;
  logic [5:0]  x_lo, x_hi, y_lo, y_hi, bx, by;
  logic [15:0] res_value;
  logic [10:0] res_touched;
  logic        res_sat;

  logic        accept, cls_ok_in, rd_in_range, out_free, last_bin, y_nonempty;
  logic [10:0] step_eff;
  logic [5:0]  nx, ny;
  logic [11:0] x_range, y_range;

  logic                  div_start, div_done;
  logic [DIV_NUM_W-1:0]  div_dividend, div_quotient;
  logic [DIV_DEN_W-1:0]  div_remainder;

  mem_ctl_t              mem_ctl;
  mem_sts_t              mem_sts;
  logic [AW-1:0]         mem_addr;
  logic [COUNT_BITS-1:0] mem_rd_data;

  // Covered window range along one axis, packed {lo, hi}.
  function automatic logic [11:0] cover_range(input logic [9:0] q, input logic [11:0] k,
                                              input logic [5:0] n);
    logic [5:0] top;
    logic [5:0] bot;
    if (n == 6'd0) begin
      top = 6'd0;
    end else if (q < {4'd0, n - 6'd1}) begin
      top = q[5:0] + 6'd1;
    end else begin
      top = n;
    end
    bot = ({6'd0, top} > k) ? top - k[5:0] : 6'd0;
    return {bot, top};
  endfunction

  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 11'd32;
      window_step <= 11'd8;
      bins_across <= 6'd32;
      bins_down   <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: window_size <= cfg_data;
        CFG_WINDOW_STEP: window_step <= cfg_data;
        CFG_BINS_ACROSS: bins_across <= cfg_data[5:0];
        CFG_BINS_DOWN:   bins_down   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign step_eff = (window_step == 11'd0) ? 11'd1 : window_step;
  assign nx = (int'(bins_across) > MAX_BINS_X) ? 6'(MAX_BINS_X) : bins_across;
  assign ny = (int'(bins_down) > MAX_BINS_Y) ? 6'(MAX_BINS_Y) : bins_down;

  assign accept      = s_tvalid && s_tready;
  assign cls_ok_in   = !s_tdata[8] && (int'(s_tdata[7:0]) < NUM_CLASSES);
  assign rd_in_range = (int'(s_tdata[18:9]) < MAX_BINS_X) && (int'(s_tdata[28:19]) < MAX_BINS_Y);
  assign out_free    = !m_tvalid || m_tready;
  assign last_bin    = (6'(bx + 6'd1) == x_hi) && (6'(by + 6'd1) == y_hi);

  // window count: ceil((size - p mod s) / s) = (size + s - 1 - r) / s
  always_comb begin
    case (div_sel)
      2'd0:    div_dividend = {2'd0, px};
      2'd2:    div_dividend = {2'd0, py};
      default: div_dividend = DIV_NUM_W'({2'd0, window_size} + {2'd0, step_eff} - 13'd1
                                         - {2'd0, r_tmp});
    endcase
  end

  assign x_range    = cover_range(q_tmp, div_quotient, nx);
  assign y_range    = cover_range(q_tmp, div_quotient, ny);
  assign y_nonempty = (y_range[11:6] < y_range[5:0]) && (x_lo < x_hi);

  always_comb begin
    if (cmd == CMD_READ) begin
      mem_addr = AW'({CW'(cls), py[YW-1:0], px[XW-1:0]});
    end else begin
      mem_addr = AW'({CW'(cls), YW'(by), XW'(bx)});
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            CMD_ADD:   state_next = cls_ok_in ? ST_DIV_START : ST_DONE;
            CMD_READ:  state_next = (cls_ok_in && rd_in_range) ? ST_FETCH : ST_DONE;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_sel == 2'd3) begin
            state_next = y_nonempty ? ST_FETCH : ST_DONE;
          end else begin
            state_next = ST_DIV_START;
          end
        end
      end
      ST_FETCH:      state_next = (cmd == CMD_READ) ? ST_PEEK : ST_UPDATE;
      ST_UPDATE:     state_next = last_bin ? ST_DONE : ST_FETCH;
      ST_PEEK:       state_next = ST_DONE;
      ST_CLEAR:      state_next = ST_CLEAR_WAIT;
      ST_CLEAR_WAIT: state_next = mem_sts.busy ? ST_CLEAR_WAIT : ST_DONE;
      ST_DONE:       state_next = out_free ? ST_IDLE : ST_DONE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready      = 1'b0;
    div_start     = 1'b0;
    mem_ctl.rd    = 1'b0;
    mem_ctl.inc   = 1'b0;
    mem_ctl.clear = 1'b0;
    case (state)
      ST_IDLE:      s_tready      = !mem_sts.busy;
      ST_DIV_START: div_start     = 1'b1;
      ST_FETCH:     mem_ctl.rd    = 1'b1;
      ST_UPDATE:    mem_ctl.inc   = 1'b1;
      ST_CLEAR:     mem_ctl.clear = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd         <= s_tuser;
      cls         <= s_tdata[7:0];
      px          <= s_tdata[18:9];
      py          <= s_tdata[28:19];
      div_sel     <= 2'd0;
      res_value   <= '0;
      res_touched <= '0;
      res_sat     <= 1'b0;
    end
    if (state == ST_DIV_WAIT && div_done) begin
      div_sel <= div_sel + 2'd1;
      case (div_sel)
        2'd1: begin
          x_lo <= x_range[11:6];
          x_hi <= x_range[5:0];
        end
        2'd3: begin
          y_lo <= y_range[11:6];
          y_hi <= y_range[5:0];
          bx   <= x_lo;
          by   <= y_range[11:6];
        end
        default: begin
          q_tmp <= div_quotient[9:0];
          r_tmp <= div_remainder;
        end
      endcase
    end
    if (state == ST_UPDATE) begin
      if (mem_sts.at_max) begin
        res_sat <= 1'b1;
      end else if (res_touched != '1) begin
        res_touched <= res_touched + 11'd1;
      end
      if (6'(bx + 6'd1) == x_hi) begin
        bx <= x_lo;
        by <= by + 6'd1;
      end else begin
        bx <= bx + 6'd1;
      end
    end
    if (state == ST_PEEK) begin
      res_value <= 16'(mem_rd_data);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {5'd0, res_touched, res_value};
      m_tuser <= res_sat;
    end
  end

  owch_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (step_eff),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  owch_store #(
    .DEPTH      (DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .addr    (mem_addr),
    .rd_data (mem_rd_data),
    .sts     (mem_sts)
  );

  a_bin_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> (bx >= x_lo && bx < x_hi && by >= y_lo && by < y_hi))
    else $error("window index outside covered range");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second request taken while one is in progress");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("waiting result changed or dropped");

endmodule

// ===== rtl/owch_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module owch_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [owch_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [owch_pkg::DIV_DEN_W-1:0]  divisor,
  output logic                            done,
  output logic [owch_pkg::DIV_NUM_W-1:0]  quotient,
  output logic [owch_pkg::DIV_DEN_W-1:0]  remainder
);
  import owch_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   trial;
  logic                 qbit;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0) && !start;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      cnt <= DIV_CNT_W'(DIV_NUM_W - 1);
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], qbit};
      // a failed trial is below the divisor, so its top bit is clear
      rem <= qbit ? DIV_DEN_W'(trial - {1'b0, divisor}) : trial[DIV_DEN_W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/owch_store.sv =====
// Counter memory with saturating increment and a one-entry-per-cycle clearing pass.
module owch_store #(
  parameter int DEPTH      = 262144,
  parameter int COUNT_BITS = 16,
  parameter int AW         = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  owch_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      addr,
  output logic [COUNT_BITS-1:0] rd_data,
  output owch_pkg::mem_sts_t sts
);
  import owch_pkg::*;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic                  sweeping;
  logic [AW-1:0]         sweep_addr;
  logic                  at_max;

  assign at_max     = (rd_data == '1);
  assign sts.busy   = sweeping;
  assign sts.at_max = at_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (ctl.clear) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      if (sweep_addr == AW'(DEPTH - 1)) begin
        sweeping <= 1'b0;
      end
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping) begin
      mem[sweep_addr] <= '0;
    end else if (ctl.inc && !at_max) begin
      mem[addr] <= rd_data + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data <= mem[addr];
    end
  end

  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !ctl.rd && !ctl.inc)
    else $error("counter access during clearing pass");

  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> sweeping)
    else $error("clear did not start clearing pass");

endmodule

// ===== bench/overlapping_window_class_histogram_checker.sv =====
// Bus monitor, histogram predictor and result comparison for the class histogram bench.
`timescale 1ns / 100ps

module overlapping_window_class_histogram_checker #(
  parameter int NUM_CLASSES = 256,
  parameter int MAX_BINS_X  = 32,
  parameter int MAX_BINS_Y  = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [owch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owch_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [owch_pkg::IN_DATA_W-1:0]   s_tdata,   // class_code[8:0], pos_x[18:9], pos_y[28:19]
  input  logic [1:0]                       s_tuser,   // cmd[1:0]
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [owch_pkg::OUT_DATA_W-1:0]  m_tdata,   // count_value[15:0], bins_touched[26:16]
  input  logic [0:0]                       m_tuser,   // saturated[0]
  output int                               pending,
  output int                               fail_count
);
  import owch_pkg::*;

  localparam int STORE_DEPTH = NUM_CLASSES * MAX_BINS_Y * MAX_BINS_X;

  typedef struct packed {
    logic [15:0] count_value;
    logic [10:0] bins_touched;
    logic        saturated;
  } hist_result_t;

  bit   [COUNT_BITS-1:0] bin_counts [STORE_DEPTH];
  logic [10:0]           win_size;
  logic [10:0]           win_step;
  logic [5:0]            cols_cfg;
  logic [5:0]            rows_cfg;
  hist_result_t          expected_results [$];
  hist_result_t          want;
  hist_result_t          got;

  // Window index range [lo, hi) that covers coordinate p along an axis of n windows.
  function automatic void covered_span(input int p, input int n, output int lo, output int hi);
    int s;
    int q;
    s = (win_step == 0) ? 1 : int'(win_step);
    q = p / s;
    if (n <= 0) begin
      lo = 0;
      hi = 0;
    end else begin
      hi = ((q < n - 1) ? q : n - 1) + 1;
      lo = hi - (int'(win_size) - (p % s) + s - 1) / s;
      if (lo < 0) lo = 0;
    end
  endfunction

  function automatic hist_result_t predict_request(input logic [1:0] cmd,
                                                   input logic signed [8:0] cls,
                                                   input logic [9:0] px,
                                                   input logic [9:0] py);
    hist_result_t r;
    bit           class_ok;
    int           nx, ny, x0, x1, y0, y1, idx, touched;
    r = '0;
    touched = 0;
    class_ok = (cls >= 0) && (int'(cls) < NUM_CLASSES);
    case (cmd)
      CMD_ADD: if (class_ok) begin
        nx = (cols_cfg > MAX_BINS_X) ? MAX_BINS_X : int'(cols_cfg);
        ny = (rows_cfg > MAX_BINS_Y) ? MAX_BINS_Y : int'(rows_cfg);
        covered_span(int'(px), nx, x0, x1);
        covered_span(int'(py), ny, y0, y1);
        for (int by = y0; by < y1; by++) begin
          for (int bx = x0; bx < x1; bx++) begin
            idx = (int'(cls) * MAX_BINS_Y + by) * MAX_BINS_X + bx;
            if (bin_counts[idx] == {COUNT_BITS{1'b1}}) begin
              r.saturated = 1'b1;
            end else begin
              bin_counts[idx] = bin_counts[idx] + 1'b1;
              if (touched < 2047) touched++;
            end
          end
        end
        r.bins_touched = 11'(touched);
      end
      CMD_READ: if (class_ok && px < MAX_BINS_X && py < MAX_BINS_Y) begin
        idx = (int'(cls) * MAX_BINS_Y + int'(py)) * MAX_BINS_X + int'(px);
        r.count_value = 16'(bin_counts[idx]);
      end
      CMD_CLEAR: foreach (bin_counts[i]) bin_counts[i] = '0;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      win_size = 11'd32;
      win_step = 11'd8;
      cols_cfg = 6'd32;
      rows_cfg = 6'd32;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_SIZE: win_size = cfg_data;
          CFG_WINDOW_STEP: win_step = cfg_data;
          CFG_BINS_ACROSS: cols_cfg = cfg_data[5:0];
          CFG_BINS_DOWN:   rows_cfg = cfg_data[5:0];
          default: ;
        endcase
      end
      // results leave before the new request is predicted, so the oldest is popped
      if (m_tvalid && m_tready) begin
        got.count_value  = m_tdata[15:0];
        got.bins_touched = m_tdata[26:16];
        got.saturated    = m_tuser[0];
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: count_value %0d, bins_touched %0d",
                 got.count_value, got.bins_touched);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.count_value !== want.count_value) begin
            $error("count_value: expected %0d, actual %0d", want.count_value, got.count_value);
            fail_count++;
          end
          if (got.bins_touched !== want.bins_touched) begin
            $error("bins_touched: expected %0d, actual %0d", want.bins_touched,
                   got.bins_touched);
            fail_count++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_request(s_tuser, s_tdata[8:0], s_tdata[18:9],
                                                   s_tdata[28:19]));
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/overlapping_window_class_histogram_top_tb.sv =====
// Stimulus, flow control and verdict for the overlapping-window class histogram.
`timescale 1ns / 100ps

module overlapping_window_class_histogram_top_tb;
  import owch_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 290;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 4_000_000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [1:0]            s_tuser   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_ready;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  int pending;
  int fail_count;
  int tx_idle_pct = 32;
  int rx_idle_pct = 83;
  int burst_req   = 0;
  int burst_seen  = 0;
  int hold_left   = 0;
  int cycles      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  overlapping_window_class_histogram_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  overlapping_window_class_histogram_checker hist_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .pending(pending), .fail_count(fail_count)
  );

  // Result side: random back-pressure, plus a long hold-off whenever one is asked for.
  always @(negedge clk) begin
    if (burst_seen != burst_req) begin
      burst_seen = burst_req;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [1:0] cmd, input logic [8:0] cls,
                              input logic [9:0] px, input logic [9:0] py);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, py, px, cls};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic load_config(input int size_v, input int step_v, input int across_v,
                             input int down_v);
    logic [CFG_IDX_W-1:0] regs [4];
    int                   vals [4];
    regs = '{CFG_WINDOW_SIZE, CFG_WINDOW_STEP, CFG_BINS_ACROSS, CFG_BINS_DOWN};
    vals = '{size_v, step_v, across_v, down_v};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i][CFG_DATA_W-1:0];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly a few classes so that reads land on live counters; reads mostly inside the store.
  task automatic random_request(output bit counted);
    int         r;
    logic [1:0] cmd;
    logic [8:0] cls;
    logic [9:0] px;
    logic [9:0] py;
    r   = $urandom_range(0, 99);
    cls = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 3));
    px  = 10'($urandom_range(0, 1023));
    py  = 10'($urandom_range(0, 1023));
    if (r < 55) begin
      cmd = CMD_ADD;
    end else if (r < 95) begin
      cmd = CMD_READ;
      if ($urandom_range(0, 7) != 0) begin
        px = 10'($urandom_range(0, 31));
        py = 10'($urandom_range(0, 31));
      end
    end else begin
      cmd = CMD_IGNORED;
    end
    counted = (cmd != CMD_IGNORED) && !cls[8];
    send_request(cmd, cls, px, py);
  endtask

  initial begin
    int step_v;
    int done;
    bit counted;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_config(32, 8, 32, 32);
    send_request(CMD_ADD, 9'd0, 10'd0, 10'd0);
    send_request(CMD_ADD, 9'd0, 10'd1023, 10'd1023);
    send_request(CMD_ADD, 9'd255, 10'd100, 10'd37);
    send_request(CMD_ADD, 9'h1FF, 10'd5, 10'd5);
    send_request(CMD_ADD, 9'h100, 10'd1023, 10'd1023);
    send_request(CMD_READ, 9'd0, 10'd0, 10'd0);
    send_request(CMD_READ, 9'd0, 10'd31, 10'd31);
    send_request(CMD_READ, 9'd255, 10'd12, 10'd4);
    send_request(CMD_READ, 9'd0, 10'd1023, 10'd1023);
    send_request(CMD_READ, 9'd0, 10'd32, 10'd0);
    send_request(CMD_READ, 9'd0, 10'd5, 10'd40);
    send_request(CMD_READ, 9'h1FF, 10'd0, 10'd0);
    send_request(CMD_IGNORED, 9'h0FF, 10'd1023, 10'd1023);
    send_request(CMD_CLEAR, 9'd0, 10'd0, 10'd0);
    send_request(CMD_READ, 9'd0, 10'd31, 10'd31);

    // zero window and zero step; no rows in use
    settle();
    load_config(0, 0, 63, 0);
    send_request(CMD_ADD, 9'd1, 10'd512, 10'd512);

    // widest windows at unit step: full 32 x 32 grid on one point
    settle();
    load_config(2047, 1, 63, 63);
    send_request(CMD_ADD, 9'd2, 10'd1023, 10'd1023);
    send_request(CMD_ADD, 9'd2, 10'd0, 10'd0);
    send_request(CMD_READ, 9'd2, 10'd0, 10'd0);

    settle();
    load_config(2047, 2047, 1, 1);
    send_request(CMD_ADD, 9'd3, 10'd1023, 10'd5);
    send_request(CMD_READ, 9'd3, 10'd0, 10'd0);

    settle();
    load_config(1, 1024, 32, 32);
    send_request(CMD_ADD, 9'd3, 10'd1023, 10'd0);
    send_request(CMD_ADD, 9'd3, 10'd0, 10'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      // window no wider than four steps keeps each add to at most 16 counters
      step_v = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 48);
      load_config($urandom_range(0, 4 * ((step_v == 0) ? 1 : step_v)), step_v,
                  $urandom_range(0, 40), $urandom_range(0, 40));
      tx_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 83 : 0;
      rx_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 32 : 0;
      if (ph == 4) burst_req++;
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_request(counted);
        if (counted) done++;
      end
    end

    settle();
    rx_idle_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
